### rtl/ccu_pkg.sv
// Console channel command unit: shared types, codes and helper functions.
// No dependencies; the core, front end, back end and checker import this package.
`default_nettype none
package ccu_pkg;

    localparam logic [1:0] FUNC_KEY   = 2'd0;
    localparam logic [1:0] FUNC_CMD   = 2'd1;
    localparam logic [1:0] FUNC_RDREQ = 2'd2;
    localparam logic [1:0] FUNC_WRBYT = 2'd3;

    localparam logic [7:0] CODE_WRITE    = 8'h01;
    localparam logic [7:0] CODE_WRITE_CR = 8'h09;
    localparam logic [7:0] CODE_NOP      = 8'h03;
    localparam logic [7:0] CODE_READ     = 8'h0A;
    localparam logic [7:0] CODE_ALARM    = 8'h0B;
    localparam logic [7:0] CODE_SENSE    = 8'h04;
    localparam logic [7:0] CODE_SENSE_ID = 8'hE4;
    localparam logic [3:0] SENSE_NIBBLE  = 4'h4;

    localparam logic [2:0] KIND_STATUS = 3'd0;
    localparam logic [2:0] KIND_READ   = 3'd1;
    localparam logic [2:0] KIND_PRINT  = 3'd2;
    localparam logic [2:0] KIND_ATTN   = 3'd3;
    localparam logic [2:0] KIND_LINE   = 3'd4;

    localparam logic [7:0] ST_ATTN = 8'h80;
    localparam logic [7:0] ST_CE   = 8'h08;
    localparam logic [7:0] ST_DE   = 8'h04;
    localparam logic [7:0] ST_UC   = 8'h02;

    localparam logic [7:0] SENSE_INTERV = 8'h40;
    localparam logic [7:0] SENSE_REJECT = 8'h80;

    localparam logic [15:0] ID_LEN     = 16'd7;
    localparam logic [7:0]  ID_FIRST   = 8'hFF;
    localparam logic [15:0] TYPE_RESET = 16'h1052;

    localparam logic CFG_DEVICE_TYPE = 1'b0;
    localparam logic CFG_CONNECTED   = 1'b1;

    typedef enum logic [2:0] {
        OP_WRITE, OP_WRITE_CR, OP_IMMED, OP_READ, OP_SENSE, OP_SENSE_ID, OP_REJECT
    } t_op;

    typedef enum logic [1:0] {
        BS_IDLE, BS_READ, BS_SECOND
    } t_bstate;

    typedef struct packed {
        logic [1:0]  func;
        t_op         op;
        logic        sense_cls;
        logic        chain;
        logic [15:0] count;
        logic [7:0]  data;
        logic        last;
    } t_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [7:0]  status;
        logic [15:0] residual;
        logic        more;
    } t_result;

    function automatic t_op classify(input logic [7:0] code);
        t_op op;
        unique case (code)
            CODE_WRITE:            op = OP_WRITE;
            CODE_WRITE_CR:         op = OP_WRITE_CR;
            CODE_NOP, CODE_ALARM:  op = OP_IMMED;
            CODE_READ:             op = OP_READ;
            CODE_SENSE:            op = OP_SENSE;
            CODE_SENSE_ID:         op = OP_SENSE_ID;
            default:               op = OP_REJECT;
        endcase
        return op;
    endfunction

    function automatic logic [7:0] id_byte(input logic [7:0] pos, input logic [15:0] dtype);
        logic [7:0] b;
        case (pos)
            8'd0:       b = ID_FIRST;
            8'd1, 8'd4: b = dtype[15:8];
            8'd2, 8'd5: b = dtype[7:0];
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

### rtl/ccu_in_if.sv
// Input channel of the console channel command unit: valid/ready plus item fields.
// No dependencies.
`default_nettype none
interface ccu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  ccw_code;
    logic        chain_data;
    logic [15:0] byte_count;
    logic [7:0]  data_in;
    logic        key_last;

    modport source (output valid, func, ccw_code, chain_data, byte_count, data_in, key_last,
                    input ready);
    modport sink   (input valid, func, ccw_code, chain_data, byte_count, data_in, key_last,
                    output ready);
endinterface
`default_nettype wire

### rtl/ccu_out_if.sv
// Result channel of the console channel command unit: valid/ready plus result fields.
// No dependencies.
`default_nettype none
interface ccu_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data_out;
    logic [7:0]  unit_status;
    logic [15:0] residual;
    logic        more_data;

    modport source (output valid, kind, data_out, unit_status, residual, more_data,
                    input ready);
    modport sink   (input valid, kind, data_out, unit_status, residual, more_data,
                    output ready);
endinterface
`default_nettype wire

### rtl/console_channel_command_unit_core.sv
// Top level of the console channel command unit: configuration registers,
// front end queue and back end executor. Depends on ccu_pkg, ccu_in_if, ccu_out_if.
//
// An item with at most one result is done in the idle state; a write byte or a sense
// read request ending its command goes to the second result state; a keyboard read
// request goes to the read state for the registered line buffer memory read, then to
// the second result state if it ends the command. A two-entry queue decouples
// acceptance from execution. The result register is refilled in the cycle its result
// is taken; while a result waits the back end holds and the queue absorbs two items.
`default_nettype none
module console_channel_command_unit_core
    import ccu_pkg::*;
#(
    parameter int LINE_BYTES = 150
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ccu_in_if.sink           in_ch,
    ccu_out_if.source        out_ch,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_wdata
);
    logic [15:0] r_device_type;
    logic        r_connected;
    logic        q_valid, q_pop;
    t_item       q_item;
    t_result     res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_type <= TYPE_RESET;
            r_connected   <= 1'b1;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_DEVICE_TYPE) begin
                r_device_type <= i_cfg_wdata;
            end else begin
                r_connected <= i_cfg_wdata[0];
            end
        end
    end

    ccu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_ch.valid),
        .o_ready      (in_ch.ready),
        .i_func       (in_ch.func),
        .i_ccw_code   (in_ch.ccw_code),
        .i_chain_data (in_ch.chain_data),
        .i_byte_count (in_ch.byte_count),
        .i_data_in    (in_ch.data_in),
        .i_key_last   (in_ch.key_last),
        .o_q_valid    (q_valid),
        .o_q_item     (q_item),
        .i_q_pop      (q_pop)
    );

    ccu_back #(.LINE_BYTES(LINE_BYTES)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .i_device_type (r_device_type),
        .i_connected   (r_connected),
        .o_valid       (out_ch.valid),
        .i_ready       (out_ch.ready),
        .o_result      (res)
    );

    assign out_ch.kind        = res.kind;
    assign out_ch.data_out    = res.data;
    assign out_ch.unit_status = res.status;
    assign out_ch.residual    = res.residual;
    assign out_ch.more_data   = res.more;
endmodule
`default_nettype wire

### rtl/ccu_front.sv
// Front end: accepts input items, decodes the command code and queues them.
// Depends on ccu_pkg.
`default_nettype none
module ccu_front
    import ccu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [7:0]  i_ccw_code,
    input  wire logic        i_chain_data,
    input  wire logic [15:0] i_byte_count,
    input  wire logic [7:0]  i_data_in,
    input  wire logic        i_key_last,
    output logic             o_q_valid,
    output t_item            o_q_item,
    input  wire logic        i_q_pop
);
    t_item      r_slot [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    logic       push;
    t_item      item;

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_slot[r_rptr];

    always_comb begin
        item.func      = i_func;
        item.op        = classify(i_ccw_code);
        item.sense_cls = (i_ccw_code[3:0] == SENSE_NIBBLE);
        item.chain     = i_chain_data;
        item.count     = i_byte_count;
        item.data      = i_data_in;
        item.last      = i_key_last;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_q_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end
endmodule
`default_nettype wire

### rtl/ccu_back.sv
// Back end: executes queued items, holds device state and the keyboard line buffer.
// Depends on ccu_pkg; fed by ccu_front.
`default_nettype none
module ccu_back
    import ccu_pkg::*;
#(
    parameter int LINE_BYTES = 150
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  wire t_item       i_q_item,
    output logic             o_q_pop,
    input  wire logic [15:0] i_device_type,
    input  wire logic        i_connected,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_result          o_result
);
    localparam int AW = $clog2(LINE_BYTES);
    localparam logic [7:0]  LB8  = 8'(LINE_BYTES);
    localparam logic [15:0] LB16 = 16'(LINE_BYTES);

    logic [7:0]  mem [LINE_BYTES];
    logic [7:0]  r_mem_q;

    t_bstate     r_state, n_state;
    logic [7:0]  r_kb_head, n_kb_head, r_kb_count, n_kb_count, r_key_fill, n_key_fill;
    logic [7:0]  r_sense, n_sense, r_latch, n_latch;
    logic        r_read_wait, n_read_wait, r_pchain, n_pchain;
    logic [15:0] r_pcount, n_pcount;
    t_op         r_op, n_op;
    logic [7:0]  r_tleft, n_tleft, r_xpos, n_xpos;
    logic        r_xmore, n_xmore;
    logic        r_rdz, n_rdz, r_pv, n_pv;
    t_result     r_p, n_p;
    logic        r_ov;
    t_result     r_o;

    logic        out_free, e_v, go_read, set_pend, wr_en, rd_en;
    t_result     e;
    t_item       it;
    logic [15:0] num, sr_count, sr_len;
    logic [7:0]  sr_num, kf_n;
    logic        sr_chain, sr_more, do_sr;

    assign out_free = !r_ov || i_ready;
    assign it       = i_q_item;
    assign o_valid  = r_ov;
    assign o_result = r_o;

    always_comb begin
        kf_n = (r_key_fill < LB8) ? r_key_fill + 8'd1 : r_key_fill;
        if (it.func == FUNC_CMD) begin
            sr_count = it.count;
            sr_chain = it.chain;
            sr_len   = {8'h00, r_kb_count};
        end else begin
            sr_count = r_pcount;
            sr_chain = r_pchain;
            sr_len   = {8'h00, kf_n};
        end
        sr_more = sr_count < sr_len;
        sr_num  = sr_more ? sr_count[7:0] : sr_len[7:0];
    end

    always_comb begin
        n_kb_head = r_kb_head;  n_kb_count = r_kb_count; n_key_fill = r_key_fill;
        n_sense = r_sense;      n_latch = r_latch;       n_read_wait = r_read_wait;
        n_pchain = r_pchain;    n_pcount = r_pcount;     n_op = r_op;
        n_tleft = r_tleft;      n_xpos = r_xpos;         n_xmore = r_xmore;
        n_rdz = r_rdz;          n_pv = r_pv;             n_p = r_p;
        o_q_pop = 1'b0; e_v = 1'b0; e = '0; go_read = 1'b0; set_pend = 1'b0;
        wr_en = 1'b0; rd_en = 1'b0; num = '0; do_sr = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    case (it.func)
                        FUNC_CMD: begin
                            n_read_wait = 1'b0;
                            n_tleft = 8'd0;
                            n_xpos = 8'd0;
                            n_op = it.op;
                            n_pchain = it.chain;
                            e.residual = it.count;
                            if (!i_connected && !it.sense_cls) begin
                                n_sense = SENSE_INTERV;
                                e_v = 1'b1;
                                e.status = ST_UC;
                            end else begin
                                unique case (it.op)
                                    OP_WRITE, OP_WRITE_CR: begin
                                        num = (it.count < LB16) ? it.count : LB16;
                                        if (num == 16'd0) begin
                                            e_v = 1'b1;
                                            e.status = ST_CE | ST_DE;
                                            e.kind = (it.op == OP_WRITE_CR && !it.chain)
                                                   ? KIND_LINE : KIND_STATUS;
                                        end else begin
                                            n_tleft = num[7:0];
                                            n_pcount = it.count - num;
                                            n_xmore = 1'b0;
                                        end
                                    end
                                    OP_IMMED: begin
                                        e_v = 1'b1;
                                        e.status = ST_CE | ST_DE;
                                    end
                                    OP_READ: begin
                                        if (r_kb_count == 8'd0) begin
                                            n_read_wait = 1'b1;
                                            n_pcount = it.count;
                                        end else begin
                                            do_sr = 1'b1;
                                        end
                                    end
                                    OP_SENSE: begin
                                        n_latch = r_sense;
                                        n_sense = 8'd0;
                                        if (it.count == 16'd0) begin
                                            e_v = 1'b1;
                                            e.status = ST_CE | ST_DE;
                                            e.more = 1'b1;
                                        end else begin
                                            n_tleft = 8'd1;
                                            n_pcount = it.count - 16'd1;
                                            n_xmore = 1'b0;
                                        end
                                    end
                                    OP_SENSE_ID: begin
                                        num = (it.count < ID_LEN) ? it.count : ID_LEN;
                                        if (num == 16'd0) begin
                                            e_v = 1'b1;
                                            e.status = ST_CE | ST_DE;
                                            e.residual = 16'd0;
                                            e.more = 1'b1;
                                        end else begin
                                            n_tleft = num[7:0];
                                            n_pcount = it.count - num;
                                            n_xmore = it.count < ID_LEN;
                                        end
                                    end
                                    default: begin
                                        n_sense = SENSE_REJECT;
                                        e_v = 1'b1;
                                        e.status = ST_CE | ST_DE | ST_UC;
                                    end
                                endcase
                            end
                        end
                        FUNC_KEY: begin
                            wr_en = r_key_fill < LB8;
                            n_key_fill = kf_n;
                            if (it.last) begin
                                n_kb_count = kf_n;
                                n_kb_head = 8'd0;
                                n_key_fill = 8'd0;
                                if (r_read_wait) begin
                                    n_read_wait = 1'b0;
                                    do_sr = 1'b1;
                                end else begin
                                    e_v = 1'b1;
                                    e.kind = KIND_ATTN;
                                    e.status = ST_ATTN;
                                end
                            end
                        end
                        FUNC_RDREQ: begin
                            if (r_tleft != 8'd0 && (r_op == OP_READ || r_op == OP_SENSE
                                                    || r_op == OP_SENSE_ID)) begin
                                n_xpos = r_xpos + 8'd1;
                                n_tleft = r_tleft - 8'd1;
                                n_pv = (r_tleft == 8'd1);
                                n_p = '0;
                                n_p.status = ST_CE | ST_DE;
                                n_p.residual = r_pcount;
                                n_p.more = r_xmore;
                                if (r_op == OP_READ) begin
                                    go_read = 1'b1;
                                    rd_en = r_kb_head < LB8;
                                    n_rdz = !(r_kb_head < LB8);
                                    n_kb_head = r_kb_head + 8'd1;
                                end else begin
                                    e_v = 1'b1;
                                    e.kind = KIND_READ;
                                    e.data = (r_op == OP_SENSE) ? r_latch
                                           : id_byte(r_xpos, i_device_type);
                                    set_pend = (r_tleft == 8'd1);
                                end
                            end
                        end
                        default: begin
                            if (r_tleft != 8'd0 && (r_op == OP_WRITE || r_op == OP_WRITE_CR)) begin
                                n_tleft = r_tleft - 8'd1;
                                e_v = 1'b1;
                                e.kind = KIND_PRINT;
                                e.data = it.data;
                                set_pend = (r_tleft == 8'd1);
                                n_p = '0;
                                n_p.kind = (r_op == OP_WRITE_CR && !r_pchain)
                                         ? KIND_LINE : KIND_STATUS;
                                n_p.status = ST_CE | ST_DE;
                                n_p.residual = r_pcount;
                            end
                        end
                    endcase
                    if (do_sr) begin
                        n_kb_count = (sr_chain && sr_more)
                                   ? 8'(sr_len - sr_count) : 8'd0;
                        if (sr_num == 8'd0) begin
                            e_v = 1'b1;
                            e.kind = KIND_STATUS;
                            e.status = ST_CE | ST_DE;
                            e.residual = sr_count;
                            e.more = sr_more;
                        end else begin
                            n_op = OP_READ;
                            n_tleft = sr_num;
                            n_xpos = 8'd0;
                            n_pcount = sr_count - {8'h00, sr_num};
                            n_xmore = sr_more;
                        end
                    end
                end
            end
            BS_READ: begin
                if (out_free) begin
                    e_v = 1'b1;
                    e.kind = KIND_READ;
                    e.data = r_rdz ? 8'h00 : r_mem_q;
                end
            end
            default: begin
                if (out_free) begin
                    e_v = 1'b1;
                    e = r_p;
                end
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (go_read) begin
                    n_state = BS_READ;
                end else if (set_pend) begin
                    n_state = BS_SECOND;
                end
            end
            BS_READ: begin
                if (out_free) begin
                    n_state = r_pv ? BS_SECOND : BS_IDLE;
                end
            end
            default: begin
                if (out_free) begin
                    n_state = BS_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_key_fill[AW-1:0]] <= it.data;
        end
        if (rd_en) begin
            r_mem_q <= mem[r_kb_head[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_v) begin
            r_o <= e;
        end
        r_p     <= n_p;
        r_rdz   <= n_rdz;
        r_latch <= n_latch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_ov        <= 1'b0;
            r_kb_head   <= 8'd0;
            r_kb_count  <= 8'd0;
            r_key_fill  <= 8'd0;
            r_sense     <= 8'd0;
            r_read_wait <= 1'b0;
            r_pchain    <= 1'b0;
            r_pcount    <= 16'd0;
            r_op        <= OP_IMMED;
            r_tleft     <= 8'd0;
            r_xpos      <= 8'd0;
            r_xmore     <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ov        <= e_v || (r_ov && !i_ready);
            r_kb_head   <= n_kb_head;
            r_kb_count  <= n_kb_count;
            r_key_fill  <= n_key_fill;
            r_sense     <= n_sense;
            r_read_wait <= n_read_wait;
            r_pchain    <= n_pchain;
            r_pcount    <= n_pcount;
            r_op        <= n_op;
            r_tleft     <= n_tleft;
            r_xpos      <= n_xpos;
            r_xmore     <= n_xmore;
            r_pv        <= n_pv;
        end
    end
endmodule
`default_nettype wire

### rtl/ccu_checker.sv
// Port-level checks on the result channel of the console channel command unit.
// Depends on ccu_pkg; bound to console_channel_command_unit_core.
`default_nettype none
module ccu_checker
    import ccu_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic [2:0]  i_kind,
    input wire logic [7:0]  i_data,
    input wire logic [7:0]  i_status,
    input wire logic        i_more
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_data))
        else $error("result dropped or changed while stalled");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_kind <= KIND_LINE)
        else $error("result kind out of range");

    a_byte_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == KIND_READ || i_kind == KIND_PRINT) |-> i_status == 8'h00)
        else $error("data byte carries status");

    a_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_more |-> i_kind == KIND_STATUS)
        else $error("more flag on non-status result");

    a_nodata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == KIND_STATUS || i_kind == KIND_ATTN || i_kind == KIND_LINE)
        |-> i_data == 8'h00)
        else $error("status result carries data");
endmodule

bind console_channel_command_unit_core ccu_checker u_ccu_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (out_ch.valid),
    .i_ready  (out_ch.ready),
    .i_kind   (out_ch.kind),
    .i_data   (out_ch.data_out),
    .i_status (out_ch.unit_status),
    .i_more   (out_ch.more_data)
);
`default_nettype wire
